// File: src/tmdu_pkg.sv
// Shared types and constants of the tape machine data unit.
package tmdu_pkg;

    // Request codes.
    localparam logic [3:0] REQ_CLEAR  = 4'd0;
    localparam logic [3:0] REQ_ADD    = 4'd1;
    localparam logic [3:0] REQ_SUB    = 4'd2;
    localparam logic [3:0] REQ_LEFT   = 4'd3;
    localparam logic [3:0] REQ_RIGHT  = 4'd4;
    localparam logic [3:0] REQ_SCAN_L = 4'd5;
    localparam logic [3:0] REQ_SCAN_R = 4'd6;
    localparam logic [3:0] REQ_STORE  = 4'd7;
    localparam logic [3:0] REQ_READ   = 4'd8;

    // Result status codes.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_MOVE_OUT = 2'd1;
    localparam logic [1:0] ST_NO_ZERO  = 2'd2;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // One request as taken from the slave stream.
    typedef struct packed {
        logic [3:0]  req_type;
        logic [11:0] step_amount;
        logic [7:0]  in_byte;
        logic        in_end;
    } t_req;

    // One finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic        valid;
        logic [7:0]  cell_value;
        logic [11:0] head_now;
        logic [1:0]  status;
    } t_result;

endpackage

// File: src/tape_machine_data_unit.sv
// Top level of the tape machine data unit: sequencer, tape memory and output register.
//
//  Channel    | Direction | tdata (low bit up)                          | tuser
//  -----------+-----------+---------------------------------------------+-----------
//  slave      | in        | req_type[3:0] step_amount[15:4] in_byte[23:16] | in_end
//  master     | out       | cell_value[7:0] head_now[19:8] zeros[23:20] | status[1:0]
//
// Cell operations, moves and reads first accept the request and read the cell memory,
// then modify, write back and hand over the result.
// Scans walk the tape memory one cell per cycle through its single read port.
// After reset a clearing pass writes zero to every cell, with o_s_tready low throughout.
// A finished result waits in the output register while the next transaction is
// taken; the sequencer holds only if a second result is ready before the first goes.
module tape_machine_data_unit
    import tmdu_pkg::*;
#(
    parameter int TAPE_DEPTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // req_type, step_amount, in_byte
    input  logic                 i_s_tuser,  // in_end
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // cell_value, head_now, zero padding
    output logic [1:0]           o_m_tuser   // status
);

    localparam int HW = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;

    t_req          req;
    t_result       res;
    logic          out_free;
    logic          mem_we;
    logic [HW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [HW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          r_out_valid;
    logic [7:0]    r_out_value;
    logic [11:0]   r_out_head;
    logic [1:0]    r_out_status;

    // Unpack the slave transaction.
    assign req.req_type    = i_s_tdata[3:0];
    assign req.step_amount = i_s_tdata[15:4];
    assign req.in_byte     = i_s_tdata[23:16];
    assign req.in_end      = i_s_tuser;

    assign out_free = !r_out_valid || i_m_tready;

    tmdu_seq #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .HW         (HW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .i_req       (req),
        .o_req_ready (o_s_tready),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tmdu_tape_ram #(
        .DEPTH (TAPE_DEPTH),
        .AW    (HW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_value  <= res.cell_value;
            r_out_head   <= res.head_now;
            r_out_status <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_head, r_out_value};
    assign o_m_tuser  = r_out_status;

endmodule

// File: src/tmdu_tape_ram.sv
// Tape cell memory: one write port and one read port with registered read data.
module tmdu_tape_ram
    import tmdu_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/tmdu_seq.sv
// Request sequencer: clearing pass, head register, scans and read-modify-write of tape cells.
module tmdu_seq
    import tmdu_pkg::*;
#(
    parameter int TAPE_DEPTH = 4096,
    parameter int HW         = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  t_req          i_req,
    output logic          o_req_ready,
    input  logic          i_out_free,
    output t_result       o_res,
    output logic          o_mem_we,
    output logic [HW-1:0] o_mem_waddr,
    output logic [7:0]    o_mem_wdata,
    output logic [HW-1:0] o_mem_raddr,
    input  logic [7:0]    i_mem_rdata
);

    // Width that holds the head, a step amount and the tape depth itself.
    localparam int CW = ((HW > 12) ? HW : 12) + 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    localparam logic [HW-1:0] LAST_ADDR = HW'(TAPE_DEPTH - 1);

    logic [2:0]    r_state, n_state;
    logic [HW-1:0] r_clr_addr, n_clr_addr;
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_scan_addr, n_scan_addr;
    logic [7:0]    r_first, n_first;
    logic [1:0]    r_status, n_status;
    t_req          r_req, n_req;
    t_result       r_res, n_res;

    logic          accept;
    logic          is_left;
    logic [CW-1:0] head_c;
    logic [CW-1:0] amt_c;
    logic [CW-1:0] diff_c;
    logic [CW-1:0] sum_c;
    logic [HW-1:0] scan_next;
    logic          scan_bound;
    logic [7:0]    first_val;
    logic          finish;
    logic [7:0]    fin_value;
    logic [HW-1:0] fin_head;
    logic [1:0]    fin_status;
    logic [CW-1:0] fin_head_c;

    assign accept      = i_req_valid && (r_state == S_IDLE);
    assign o_req_ready = (r_state == S_IDLE);

    // Head arithmetic for moves and the scan walker.
    assign head_c     = CW'(r_head);
    assign amt_c      = CW'(i_req.step_amount);
    assign diff_c     = head_c - amt_c;
    assign sum_c      = head_c + amt_c;
    assign is_left    = (r_req.req_type == REQ_SCAN_L);
    assign scan_next  = is_left ? (r_scan_addr - 1'b1) : (r_scan_addr + 1'b1);
    assign scan_bound = is_left ? (r_scan_addr == '0) : (r_scan_addr == LAST_ADDR);
    assign first_val  = (r_state == S_SCAN) ? r_first : i_mem_rdata;
    assign fin_head_c = CW'(fin_head);

    // Next-state and memory control.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_head      = r_head;
        n_scan_addr = r_scan_addr;
        n_first     = r_first;
        n_status    = r_status;
        n_req       = r_req;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = 8'd0;
        o_mem_raddr = r_head;
        finish      = 1'b0;
        fin_value   = i_mem_rdata;
        fin_head    = r_head;
        fin_status  = r_status;
        o_res       = '0;

        case (r_state)
            S_CLR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req       = i_req;
                    n_status    = ST_DONE;
                    n_scan_addr = r_head;
                    n_state     = S_EXEC;
                    if (i_req.req_type == REQ_LEFT) begin
                        if (amt_c > head_c) begin
                            n_status = ST_MOVE_OUT;
                        end else begin
                            n_head = diff_c[HW-1:0];
                        end
                    end else if (i_req.req_type == REQ_RIGHT) begin
                        if (sum_c >= CW'(TAPE_DEPTH)) begin
                            n_status = ST_MOVE_OUT;
                        end else begin
                            n_head = sum_c[HW-1:0];
                        end
                    end
                    // Read the cell under the head as it stands after the request.
                    o_mem_raddr = n_head;
                end
            end
            S_EXEC, S_SCAN: begin
                if ((r_req.req_type == REQ_SCAN_L) || (r_req.req_type == REQ_SCAN_R)) begin
                    // One cell checked per cycle, the next read issued alongside.
                    if (i_mem_rdata == 8'd0) begin
                        finish     = 1'b1;
                        fin_value  = 8'd0;
                        fin_head   = r_scan_addr;
                        fin_status = ST_DONE;
                        n_head     = r_scan_addr;
                    end else if (scan_bound) begin
                        finish     = 1'b1;
                        fin_value  = first_val;
                        fin_status = ST_NO_ZERO;
                    end else begin
                        o_mem_raddr = scan_next;
                        n_scan_addr = scan_next;
                        n_first     = first_val;
                        n_state     = S_SCAN;
                    end
                end else begin
                    finish = 1'b1;
                    case (r_req.req_type)
                        REQ_CLEAR: begin
                            o_mem_we = 1'b1;
                        end
                        REQ_ADD: begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = i_mem_rdata + r_req.step_amount[7:0];
                        end
                        REQ_SUB: begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = i_mem_rdata - r_req.step_amount[7:0];
                        end
                        REQ_STORE: begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = r_req.in_end ? 8'd0 : r_req.in_byte;
                        end
                        default: begin
                            o_mem_we = 1'b0;
                        end
                    endcase
                    if (o_mem_we) begin
                        fin_value = o_mem_wdata;
                    end
                end
            end
            S_HOLD: begin
                if (i_out_free) begin
                    o_res   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hand the result over at once, or park it until the output register frees.
        if (finish) begin
            n_res.valid      = 1'b1;
            n_res.cell_value = fin_value;
            n_res.head_now   = fin_head_c[11:0];
            n_res.status     = fin_status;
            if (i_out_free) begin
                o_res   = n_res;
                n_state = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_head     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_head     <= n_head;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_first     <= n_first;
        r_status    <= n_status;
        r_req       <= n_req;
        r_res       <= n_res;
    end

endmodule

// File: src/tmdu_checker.sv
// Port-level checker for the tape machine data unit and its bind.
module tmdu_checker
    import tmdu_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [S_TDATA_W-1:0] i_s_tdata,
    input logic                 i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata,
    input logic [1:0]           o_m_tuser
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // Only the three defined status codes ever appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == ST_DONE) || (o_m_tuser == ST_MOVE_OUT)
                        || (o_m_tuser == ST_NO_ZERO)))
        else $error("undefined status code");

    // One request at a time: the cycle after a transaction is never ready.
    a_one_at_a_time: assert property (@(posedge i_clk)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while one is in progress");

    // The clearing pass follows reset, so no request is taken straight after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("ready during the clearing pass");

endmodule

bind tape_machine_data_unit tmdu_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
